### rtl/lfu_pkg.sv
// Shared constants and types for the LFU cache.
package lfu_pkg;

  // Fixed field widths
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Read value returned by a get that misses
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // Request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // What the candidate chain looks for during a sweep
  typedef enum logic {
    MODE_FREE   = 1'b0,  // lowest-index empty entry
    MODE_VICTIM = 1'b1   // lowest count, oldest touch among valid entries
  } search_mode_t;

  // Update command from the controller to one cell
  typedef struct packed {
    logic sel;         // this cell is the target of the update
    logic touch;       // a touch happens this cycle (rank shuffle)
    logic insert;      // target loads a new key/value pair
    logic write_data;  // target replaces its data (set on a hit)
  } cell_cmd_t;

  // Status from one cell to the controller
  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

endpackage

### rtl/lfu_req_if.sv
// Request channel: valid/ready handshake carrying one get or set word.
interface lfu_req_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

### rtl/lfu_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

### rtl/lfu_cache_unit.sv
// LFU cache top level: controller, capacity register and a row of entry cells.
// Fully associative key/value cache with least-frequently-used replacement
// and oldest-touch tie break. A get, a hit, or a set that is ignored (capacity
// zero) ends after the lookup: the request is latched, then all cells compare the key
// in parallel and the result word is registered on the response channel; the
// next request is taken on the following cycle. A set that inserts goes on after
// the lookup: a candidate sweeps the row of cells one cell per clock to find
// the lowest-index free entry or the replacement victim, the apply state
// writes it, and the next request is taken on the cycle after that. The
// response word of an insert is already issued after the lookup. A waiting
// response stalls the lookup cycle only. Capacity is written through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce
// this, the user must keep to it. Values above ENTRIES act as ENTRIES.
module lfu_cache_unit import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  lfu_req_if.sink          in_req,
  lfu_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_APPLY  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]         cap_r;
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  search_mode_t             mode_r, mode_nxt;

  logic                     req_set_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] value_r;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r;
  logic signed [DATA_W-1:0] out_value_r;

  // Per-cell wiring
  cell_cmd_t                cmd      [ENTRIES];
  cell_stat_t               stat     [ENTRIES];
  logic [IDX_W-1:0]         rank     [ENTRIES];
  logic signed [DATA_W-1:0] data     [ENTRIES];
  logic [ENTRIES-1:0]       match_vec;
  logic [ENTRIES-1:0]       valid_vec;
  logic [ENTRIES-1:0]       sel_vec;

  // Candidate chain, link 0 is the empty candidate
  logic                     cand_found [ENTRIES+1];
  logic [COUNT_BITS-1:0]    cand_count [ENTRIES+1];
  logic [IDX_W-1:0]         cand_rank  [ENTRIES+1];
  logic [IDX_W-1:0]         cand_idx   [ENTRIES+1];

  logic                     out_free;
  logic                     step;
  logic                     hit_any;
  logic                     cache_full;
  logic                     do_insert;
  logic                     touch_en;
  logic                     insert_en;
  logic                     wdata_en;
  logic [IDX_W-1:0]         old_rank;
  logic signed [DATA_W-1:0] hit_data;

  assign cand_found[0] = 1'b0;
  assign cand_count[0] = '0;
  assign cand_rank[0]  = '0;
  assign cand_idx[0]   = '0;

  // Row of cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd[g]),
      .old_rank       (old_rank),
      .key_i          (key_r),
      .value_i        (value_r),
      .mode           (mode_r),
      .stat_o         (stat[g]),
      .rank_o         (rank[g]),
      .data_o         (data[g]),
      .cand_in_found  (cand_found[g]),
      .cand_in_count  (cand_count[g]),
      .cand_in_rank   (cand_rank[g]),
      .cand_in_idx    (cand_idx[g]),
      .cand_out_found (cand_found[g+1]),
      .cand_out_count (cand_count[g+1]),
      .cand_out_rank  (cand_rank[g+1]),
      .cand_out_idx   (cand_idx[g+1])
    );
    assign match_vec[g] = stat[g].match;
    assign valid_vec[g] = stat[g].valid;
  end

  // Hit data and old rank of the target: OR of one-hot selected entries
  always_comb begin
    hit_data = '0;
    old_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_data = hit_data | data[i];
      end
      if (sel_vec[i]) begin
        old_rank = old_rank | rank[i];
      end
    end
  end

  // Lookup decisions
  assign out_free   = !out_valid_r || out_rsp.ready;
  assign step       = (state_r == S_LOOK) && out_free;
  assign hit_any    = |match_vec;
  assign cache_full = (CMP_W'(occ_r) >= CMP_W'(cap_r)) || (CMP_W'(occ_r) == ENTRIES_C);
  assign do_insert  = (req_set_r == REQ_SET) && !hit_any && (cap_r != '0);

  // Cell update commands
  always_comb begin
    touch_en  = 1'b0;
    insert_en = 1'b0;
    wdata_en  = 1'b0;
    sel_vec   = '0;
    if (step && hit_any) begin
      touch_en = 1'b1;
      wdata_en = (req_set_r == REQ_SET);
      sel_vec  = match_vec;
    end else if (state_r == S_APPLY) begin
      touch_en  = 1'b1;
      insert_en = 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        sel_vec[i] = (cand_idx[ENTRIES] == IDX_W'(i));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cmd[i].sel        = sel_vec[i];
      cmd[i].touch      = touch_en;
      cmd[i].insert     = insert_en;
      cmd[i].write_data = wdata_en;
    end
  end

  // Controller
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    occ_nxt   = occ_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (do_insert) begin
            state_nxt = S_SEARCH;
            cnt_nxt   = '0;
            mode_nxt  = cache_full ? MODE_VICTIM : MODE_FREE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SEARCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_IDLE;
        if (mode_r == MODE_FREE) begin
          occ_nxt = occ_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mode_r  <= MODE_FREE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Request latch
  assign in_req.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_set_r <= in_req.req_type;
      key_r     <= in_req.key;
      value_r   <= in_req.value;
    end
  end

  // Response register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_hit_r <= hit_any;
      if (req_set_r == REQ_SET) begin
        out_value_r <= '0;
      end else if (hit_any) begin
        out_value_r <= hit_data;
      end else begin
        out_value_r <= MISS_VALUE;
      end
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.hit        = out_hit_r;
  assign out_rsp.read_value = out_value_r;

`ifndef SYNTH
  // Keys are unique among valid entries
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> $onehot0(match_vec))
    else $error("more than one entry matches the key");

  // Occupancy counter tracks the valid bits
  a_occ_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy counter out of step with valid bits");

  // The sweep always finds a slot before the write
  a_sweep_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> cand_found[ENTRIES])
    else $error("candidate sweep ended without a slot");

  // A free-slot insert never targets a valid entry
  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && mode_r == MODE_FREE) |-> ((sel_vec & valid_vec) == '0))
    else $error("free-slot insert hits a valid entry");

  // A lookup that proceeds always posts a response word
  a_look_posts: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("lookup finished without a response word");
`endif

endmodule

### rtl/lfu_cell.sv
// One cache entry plus its stage of the replacement candidate chain.
module lfu_cell import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int INDEX      = 0,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic [IDX_W-1:0]         old_rank,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  search_mode_t             mode,
  output cell_stat_t               stat_o,
  output logic [IDX_W-1:0]         rank_o,
  output logic signed [DATA_W-1:0] data_o,
  // candidate from the left neighbor
  input  logic                     cand_in_found,
  input  logic [COUNT_BITS-1:0]    cand_in_count,
  input  logic [IDX_W-1:0]         cand_in_rank,
  input  logic [IDX_W-1:0]         cand_in_idx,
  // candidate to the right neighbor
  output logic                     cand_out_found,
  output logic [COUNT_BITS-1:0]    cand_out_count,
  output logic [IDX_W-1:0]         cand_out_rank,
  output logic [IDX_W-1:0]         cand_out_idx
);

  localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);

  logic                     valid_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] data_r;
  logic [COUNT_BITS-1:0]    count_r;
  logic [IDX_W-1:0]         rank_r;

  logic                     cand_found_r;
  logic [COUNT_BITS-1:0]    cand_count_r;
  logic [IDX_W-1:0]         cand_rank_r;
  logic [IDX_W-1:0]         cand_idx_r;

  logic own_ok;
  logic take_own;

  // Lookup status
  assign stat_o.valid = valid_r;
  assign stat_o.match = valid_r && (key_r == key_i);
  assign rank_o       = rank_r;
  assign data_o       = data_r;

  // Candidate stage: keep the better of the incoming candidate and this entry
  always_comb begin
    own_ok = (mode == MODE_FREE) ? !valid_r : valid_r;
    if (mode == MODE_FREE) begin
      // earlier index wins
      take_own = own_ok && !cand_in_found;
    end else begin
      take_own = own_ok && (!cand_in_found || (count_r < cand_in_count) ||
                            ((count_r == cand_in_count) && (rank_r < cand_in_rank)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_found_r <= 1'b0;
    end else begin
      cand_found_r <= take_own || cand_in_found;
    end
    cand_count_r <= take_own ? count_r : cand_in_count;
    cand_rank_r  <= take_own ? rank_r  : cand_in_rank;
    cand_idx_r   <= take_own ? MY_IDX  : cand_in_idx;
  end

  assign cand_out_found = cand_found_r;
  assign cand_out_count = cand_count_r;
  assign cand_out_rank  = cand_rank_r;
  assign cand_out_idx   = cand_idx_r;

  // Entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= MY_IDX;
    end else if (cmd.touch) begin
      if (cmd.sel) begin
        rank_r <= TOP_RANK;
        if (cmd.insert) begin
          valid_r <= 1'b1;
        end
      end else if (rank_r > old_rank) begin
        rank_r <= rank_r - 1'b1;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.touch && cmd.sel) begin
      if (cmd.insert) begin
        key_r   <= key_i;
        data_r  <= value_i;
        count_r <= COUNT_BITS'(1);
      end else begin
        if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
        if (cmd.write_data) begin
          data_r <= value_i;
        end
      end
    end
  end

endmodule
